>>> rtl/core/rccfp_pkg.sv
// Shared constants and types for the radio-control channel frame parser.
package rccfp_pkg;

	localparam int MAX_CHANNELS = 14;
	localparam int CNT_W = 4;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int POS_W = 5;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h20;
	localparam logic [BYTE_W-1:0] CMD_BYTE = 8'h40;
	localparam logic [WORD_W-1:0] SUM_INIT = 16'hFFFF;
	localparam logic [CNT_W-1:0] COUNT_RESET = 4'd14;

	localparam logic [POS_W-1:0] POS_HUNT = 5'd0;
	localparam logic [POS_W-1:0] POS_CMD = 5'd1;
	localparam logic [POS_W-1:0] POS_CK_LOW = 5'd30;
	localparam logic [POS_W-1:0] POS_CK_HIGH = 5'd31;

	typedef struct packed {
		logic valid;
		logic [CNT_W-1:0] count;
	} job_ctl_t;

endpackage

>>> rtl/core/rc_channel_frame_parser.sv
// Top level of the radio-control channel frame parser.
// Usage:
//   Input queue: drive rx_byte with push; a byte transfers when push is high and full is
//   low. One byte per cycle is taken while full is low. full rises only on the final
//   checksum byte of a frame while both queued frame snapshots still wait to be reported.
//   Result queue: while empty is low, channel_index, channel_value and last show the
//   oldest channel; it transfers when pop is high. last marks a frame's final channel.
//   Config: cfg_data carries the channel limit; it is written when cfg_valid is high
//   (cfg_ready is always high). Values above MAX_CHANNELS act as MAX_CHANNELS.
// Timing: a good frame's snapshot is queued by the edge that transfers its final byte;
//   its first channel is registered once it heads the queue and the reporter's single
//   output register is free; channels then follow one per cycle while pop is high.
//   A frame with a bad checksum or a zero count reports nothing.
// Reset: parser returns to header hunt, queues empty, the channel limit becomes 14.
// Stalls: while pop is low the current channel holds; parsing continues into a two-frame
//   snapshot queue; once that queue is full, full holds the next frame's final byte.
module rc_channel_frame_parser #(
	parameter int MAX_CHANNELS = rccfp_pkg::MAX_CHANNELS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [rccfp_pkg::BYTE_W-1:0]   rx_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic [rccfp_pkg::CNT_W-1:0]    channel_index,
	output logic [rccfp_pkg::WORD_W-1:0]   channel_value,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rccfp_pkg::CNT_W-1:0]    cfg_data
);
	import rccfp_pkg::*;

	logic [CNT_W-1:0] chan_limit_q;
	logic             job_full;
	logic             job_push;
	logic [CNT_W-1:0] job_count;
	logic [MAX_CHANNELS-1:0][WORD_W-1:0] push_words;
	logic [MAX_CHANNELS-1:0][WORD_W-1:0] head_words;
	job_ctl_t         head_ctl;
	logic             job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chan_limit_q <= COUNT_RESET;
		else if (cfg_valid && cfg_ready)
			chan_limit_q <= cfg_data;
	end

	rccfp_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.chan_limit    (chan_limit_q),
		.job_full      (job_full),
		.job_push      (job_push),
		.job_count     (job_count),
		.job_words     (push_words)
	);

	rccfp_job_fifo #(.MAX_CHANNELS(MAX_CHANNELS)) u_job_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_push),
		.wr_count (job_count),
		.wr_words (push_words),
		.wr_full  (job_full),
		.rd_en    (job_pop),
		.rd_ctl   (head_ctl),
		.rd_words (head_words)
	);

	rccfp_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_ctl       (head_ctl),
		.job_words     (head_words),
		.job_pop       (job_pop),
		.empty         (empty),
		.pop           (pop),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last          (last)
	);

endmodule

>>> rtl/core/rccfp_front.sv
// Byte parser: tracks frame position and checksum, stores channel words, queues good frames.
module rccfp_front #(
	parameter int MAX_CHANNELS = rccfp_pkg::MAX_CHANNELS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        push,
	output logic                                        full,
	input  logic [rccfp_pkg::BYTE_W-1:0]                rx_byte,
	input  logic [rccfp_pkg::CNT_W-1:0]                 chan_limit,
	input  logic                                        job_full,
	output logic                                        job_push,
	output logic [rccfp_pkg::CNT_W-1:0]                 job_count,
	output logic [MAX_CHANNELS-1:0][rccfp_pkg::WORD_W-1:0] job_words
);
	import rccfp_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHANNELS);

	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] sum_q;
	logic [BYTE_W-1:0] low_q;
	logic [MAX_CHANNELS-1:0][WORD_W-1:0] store_q;

	logic              accept;
	logic [CNT_W-1:0]  eff_count;
	logic [CNT_W-1:0]  idx;
	logic [WORD_W-1:0] sum_next;
	logic [WORD_W-1:0] rx_sum;
	logic              sum_ok;

	assign full      = (pos_q == POS_CK_HIGH) && job_full;
	assign accept    = push && !full;
	assign eff_count = (chan_limit > MAX_CNT) ? MAX_CNT : chan_limit;
	assign idx       = CNT_W'(pos_q[POS_W-1:1]) - CNT_W'(1);
	assign sum_next  = sum_q - {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
	assign rx_sum    = {rx_byte, low_q};
	assign sum_ok    = (rx_sum == sum_q);

	assign job_push  = accept && (pos_q == POS_CK_HIGH) && sum_ok && (eff_count != '0);
	assign job_count = eff_count;
	assign job_words = store_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else if (accept) begin
			case (pos_q)
				POS_HUNT: begin
					if (rx_byte == HDR_BYTE)
						pos_q <= POS_CMD;
				end
				POS_CMD: begin
					pos_q <= (rx_byte == CMD_BYTE) ? POS_W'(2) : POS_HUNT;
				end
				POS_CK_LOW:  pos_q <= POS_CK_HIGH;
				POS_CK_HIGH: pos_q <= POS_HUNT;
				default:     pos_q <= pos_q + POS_W'(1);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (pos_q)
				POS_HUNT: begin
					if (rx_byte == HDR_BYTE)
						sum_q <= SUM_INIT - {{(WORD_W-BYTE_W){1'b0}}, HDR_BYTE};
				end
				POS_CMD: begin
					if (rx_byte == CMD_BYTE)
						sum_q <= sum_next;
				end
				POS_CK_LOW:  low_q <= rx_byte;
				POS_CK_HIGH: ;
				default: begin
					sum_q <= sum_next;
					if (idx < eff_count && !pos_q[0])
						low_q <= rx_byte;
				end
			endcase
		end
	end

	for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_store
		always_ff @(posedge clk) begin
			if (accept && pos_q != POS_HUNT && pos_q != POS_CMD && pos_q != POS_CK_LOW
				&& pos_q != POS_CK_HIGH && pos_q[0] && idx < eff_count
				&& idx == CNT_W'(k))
				store_q[k] <= {rx_byte, low_q};
		end
	end

endmodule

>>> rtl/core/rccfp_job_fifo.sv
// Two-entry queue of frame snapshots between the parser and the reporter.
module rccfp_job_fifo #(
	parameter int MAX_CHANNELS = rccfp_pkg::MAX_CHANNELS
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            wr_en,
	input  logic [rccfp_pkg::CNT_W-1:0]                     wr_count,
	input  logic [MAX_CHANNELS-1:0][rccfp_pkg::WORD_W-1:0]  wr_words,
	output logic                                            wr_full,
	input  logic                                            rd_en,
	output rccfp_pkg::job_ctl_t                             rd_ctl,
	output logic [MAX_CHANNELS-1:0][rccfp_pkg::WORD_W-1:0]  rd_words
);
	import rccfp_pkg::*;

	logic [1:0][MAX_CHANNELS-1:0][WORD_W-1:0] words_q;
	logic [1:0][CNT_W-1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_full      = (fill_q == 2'd2);
	assign do_wr        = wr_en && !wr_full;
	assign do_rd        = rd_en && (fill_q != 2'd0);
	assign rd_ctl.valid = (fill_q != 2'd0);
	assign rd_ctl.count = count_q[rd_ptr_q];
	assign rd_words     = words_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd)
				fill_q <= fill_q + 2'd1;
			else if (do_rd && !do_wr)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			words_q[wr_ptr_q] <= wr_words;
			count_q[wr_ptr_q] <= wr_count;
		end
	end

endmodule

>>> rtl/core/rccfp_back.sv
// Reporter: walks a queued frame, one channel per cycle unless pop stalls.
module rccfp_back #(
	parameter int MAX_CHANNELS = rccfp_pkg::MAX_CHANNELS
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  rccfp_pkg::job_ctl_t                             job_ctl,
	input  logic [MAX_CHANNELS-1:0][rccfp_pkg::WORD_W-1:0]  job_words,
	output logic                                            job_pop,
	output logic                                            empty,
	input  logic                                            pop,
	output logic [rccfp_pkg::CNT_W-1:0]                     channel_index,
	output logic [rccfp_pkg::WORD_W-1:0]                    channel_value,
	output logic                                            last
);
	import rccfp_pkg::*;

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic              out_valid_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  index_q;
	logic [WORD_W-1:0] value_q;
	logic              last_q;
	logic              slot_free;
	logic              emit;
	logic              is_last;

	assign slot_free     = !out_valid_q || pop;
	assign emit          = job_ctl.valid && slot_free;
	assign is_last       = (idx_q + CNT_W'(1)) == job_ctl.count;
	assign job_pop       = emit && is_last;
	assign empty         = !out_valid_q;
	assign channel_index = index_q;
	assign channel_value = value_q;
	assign last          = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + CNT_W'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			index_q <= idx_q;
			value_q <= job_words[idx_q[IDX_W-1:0]];
			last_q  <= is_last;
		end
	end

endmodule
